FILE: hw/rtl/svf_pkg.sv
// Shared types, constants and helper functions for the servo feed sequencer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package svf_pkg;

	localparam int ANGLE_W = 8;
	localparam int DUR_W   = 16;
	localparam int MS_W    = 27;
	localparam int DET_W   = 9;
	localparam int CMD_W   = 2;

	localparam logic [ANGLE_W-1:0] MAX_ANGLE        = 8'd180;
	localparam logic [ANGLE_W-1:0] REST_ANGLE_RESET = 8'd90;
	localparam int unsigned        DETACH_DELAY_DEF = 400;
	localparam logic [MS_W-1:0]    MS_PER_SEC       = 27'd1000;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK           = 2'd0,
		CMD_DISPENSE       = 2'd1,
		CMD_DISPENSE_INTER = 2'd2,
		CMD_NOP            = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               command;
		logic [ANGLE_W-1:0] feed_angle;
		logic [ANGLE_W-1:0] intermediate_angle;
		logic [MS_W-1:0]    feed_ms;
		logic [MS_W-1:0]    return_ms;
	} item_t;

	function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] a);
		sat_angle = (a > MAX_ANGLE) ? MAX_ANGLE : a;
	endfunction

	function automatic logic [MS_W-1:0] arm_ms(input logic [MS_W-1:0] ms);
		arm_ms = (ms == '0) ? MS_W'(1) : ms;
	endfunction

endpackage

FILE: hw/rtl/svf_if.sv
// Valid/ready channel interfaces for command beats and result beats.
// Depends on svf_pkg for field widths.
`timescale 1ns / 1ps

interface svf_cmd_if;
	import svf_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [ANGLE_W-1:0] feed_angle;
	logic [ANGLE_W-1:0] intermediate_angle;
	logic [DUR_W-1:0]   duration_sec;

	modport source (output valid, command, feed_angle, intermediate_angle, duration_sec,
		input ready);
	modport sink (input valid, command, feed_angle, intermediate_angle, duration_sec,
		output ready);
endinterface

interface svf_res_if;
	import svf_pkg::*;

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] servo_angle;
	logic               attached;
	logic               position_written;
	logic               return_armed;
	logic               intermediate_armed;
	logic               detach_armed;

	modport source (output valid, servo_angle, attached, position_written, return_armed,
		intermediate_armed, detach_armed, input ready);
	modport sink (input valid, servo_angle, attached, position_written, return_armed,
		intermediate_armed, detach_armed, output ready);
endinterface

FILE: hw/rtl/svf_in_stage.sv
// Input register of the sequencer: captures a command beat and converts its
// duration to milliseconds. Depends on svf_pkg and svf_cmd_if.
`timescale 1ns / 1ps

module svf_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	svf_cmd_if.sink         item,
	input  logic            advance,
	output logic            valid_s1,
	output svf_pkg::item_t  item_s1
);
	import svf_pkg::*;

	logic [DUR_W:0] ret_sec;

	assign item.ready = !valid_s1 || advance;
	assign ret_sec    = {1'b0, item.duration_sec} + {2'b0, item.duration_sec[DUR_W-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.command            <= cmd_t'(item.command);
			item_s1.feed_angle         <= item.feed_angle;
			item_s1.intermediate_angle <= item.intermediate_angle;
			item_s1.feed_ms            <= MS_W'(item.duration_sec) * MS_PER_SEC;
			item_s1.return_ms          <= MS_W'(ret_sec) * MS_PER_SEC;
		end
	end

endmodule

FILE: hw/rtl/svf_core.sv
// Sequencer state, the three one-shot timers and the result register.
// Depends on svf_pkg and svf_res_if.
`timescale 1ns / 1ps

module svf_core #(
	parameter int unsigned DETACH_DELAY_MS = svf_pkg::DETACH_DELAY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [svf_pkg::ANGLE_W-1:0] cfg_wdata,
	input  logic                        valid_s1,
	input  svf_pkg::item_t              item_s1,
	output logic                        advance,
	svf_res_if.source                   result
);
	import svf_pkg::*;

	localparam logic [DET_W-1:0] DETACH_ARM = DET_W'(DETACH_DELAY_MS);

	logic [ANGLE_W-1:0] rest_angle_q;
	logic               attached_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [ANGLE_W-1:0] inter_q;
	logic [MS_W-1:0]    ret_q;
	logic [MS_W-1:0]    int_q;
	logic [DET_W-1:0]   det_q;

	logic               attached_n;
	logic [ANGLE_W-1:0] angle_n;
	logic [ANGLE_W-1:0] inter_n;
	logic [MS_W-1:0]    ret_n;
	logic [MS_W-1:0]    int_n;
	logic [DET_W-1:0]   det_n;
	logic               written_n;

	assign advance = valid_s1 && (!result.valid || result.ready);

	always_comb begin
		attached_n = attached_q;
		angle_n    = angle_q;
		inter_n    = inter_q;
		ret_n      = ret_q;
		int_n      = int_q;
		det_n      = det_q;
		written_n  = 1'b0;
		case (item_s1.command)
			CMD_TICK: begin
				if (det_q != '0) begin
					det_n = det_q - DET_W'(1);
				end
				if (int_q != '0) begin
					int_n = int_q - MS_W'(1);
				end
				if (ret_q != '0) begin
					ret_n = ret_q - MS_W'(1);
				end
				if (det_q == DET_W'(1)) begin
					attached_n = 1'b0;
				end
				if (int_q == MS_W'(1)) begin
					angle_n   = sat_angle(inter_q);
					written_n = 1'b1;
				end
				if (ret_q == MS_W'(1)) begin
					angle_n   = sat_angle(rest_angle_q);
					det_n     = (DETACH_ARM == '0) ? DET_W'(1) : DETACH_ARM;
					written_n = 1'b1;
				end
			end
			CMD_DISPENSE: begin
				attached_n = 1'b1;
				angle_n    = sat_angle(item_s1.feed_angle);
				ret_n      = arm_ms(item_s1.feed_ms);
				written_n  = 1'b1;
			end
			CMD_DISPENSE_INTER: begin
				attached_n = 1'b1;
				inter_n    = item_s1.intermediate_angle;
				angle_n    = sat_angle(item_s1.feed_angle);
				int_n      = arm_ms(item_s1.feed_ms);
				ret_n      = arm_ms(item_s1.return_ms);
				written_n  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_angle_q <= REST_ANGLE_RESET;
		end else if (cfg_we) begin
			rest_angle_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q   <= 1'b0;
			angle_q      <= REST_ANGLE_RESET;
			inter_q      <= '0;
			ret_q        <= '0;
			int_q        <= '0;
			det_q        <= '0;
			result.valid <= 1'b0;
		end else begin
			if (advance) begin
				attached_q   <= attached_n;
				angle_q      <= angle_n;
				inter_q      <= inter_n;
				ret_q        <= ret_n;
				int_q        <= int_n;
				det_q        <= det_n;
				result.valid <= 1'b1;
			end else if (result.ready) begin
				result.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result.servo_angle        <= angle_n;
			result.attached           <= attached_n;
			result.position_written   <= written_n;
			result.return_armed       <= ret_n != '0;
			result.intermediate_armed <= int_n != '0;
			result.detach_armed       <= det_n != '0;
		end
	end

endmodule

FILE: hw/rtl/servo_feed_sequencer.sv
// Top level of the servo feed sequencer: input stage and sequencing core.
// Depends on svf_pkg, svf_if, svf_in_stage and svf_core.
//
//   channel   direction  handshake            beat contents
//   item      in         item.valid/ready     command, angles, duration in seconds
//   result    out        result.valid/ready   angle, attach and timer status
//   cfg       in         cfg_we               rest angle
//
// One beat is taken every cycle while the result channel does not stall; the input
// register takes the beat, and the result register, which sits behind the timer
// logic, holds its result.
// Reset leaves the servo detached at 90 degrees with all timers stopped.
// A stalled result holds the item stage, which then holds the input channel.
`timescale 1ns / 1ps

module servo_feed_sequencer #(
	parameter int unsigned DETACH_DELAY_MS = svf_pkg::DETACH_DELAY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	svf_cmd_if.sink                     item,
	svf_res_if.source                   result,
	input  logic                        cfg_we,
	input  logic [svf_pkg::ANGLE_W-1:0] cfg_wdata
);
	import svf_pkg::*;

	logic  valid_s1;
	logic  advance;
	item_t item_s1;

	svf_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	svf_core #(
		.DETACH_DELAY_MS (DETACH_DELAY_MS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.result    (result)
	);

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the servo feed sequencer: drives command beats,
// predicts every status beat and compares it field by field.
// Depends on svf_pkg, the svf_if channel interfaces and servo_feed_sequencer.
`timescale 1ns / 1ps

module tb_top;
	import svf_pkg::*;

	localparam int unsigned DETACH_MS = 400;
	localparam int unsigned TICKS_PER_SEC = 1000;
	localparam logic [7:0] ANGLE_LIMIT = 8'd180;

	typedef struct {
		logic [7:0] servo_angle;
		logic       attached;
		logic       position_written;
		logic       return_armed;
		logic       intermediate_armed;
		logic       detach_armed;
	} status_t;

	class servo_status_board;
		logic [7:0]  rest_deg;
		logic        drive_on;
		logic [7:0]  angle_now;
		logic [7:0]  held_inter;
		int unsigned return_left;
		int unsigned inter_left;
		int unsigned detach_left;
		status_t     expected_status[$];
		int unsigned errors;

		function new();
			rest_deg    = 8'd90;
			drive_on    = 1'b0;
			angle_now   = 8'd90;
			held_inter  = 8'd0;
			return_left = 0;
			inter_left  = 0;
			detach_left = 0;
			errors      = 0;
		endfunction

		function logic [7:0] clip_angle(logic [7:0] a);
			return (a > ANGLE_LIMIT) ? ANGLE_LIMIT : a;
		endfunction

		function int unsigned load_delay(int unsigned ms);
			return (ms == 0) ? 1 : ms;
		endfunction

		function void set_rest(logic [7:0] v);
			rest_deg = v;
		endfunction

		function int unsigned count();
			return expected_status.size();
		endfunction

		function void note_command(cmd_t c, logic [7:0] feed, logic [7:0] inter,
			logic [15:0] dur);
			status_t     s;
			bit          fire_ret;
			bit          fire_int;
			bit          fire_det;
			int unsigned secs;
			fire_ret = 0;
			fire_int = 0;
			fire_det = 0;
			secs = 32'(dur);
			s.position_written = 1'b0;
			case (c)
				CMD_TICK: begin
					if (detach_left != 0) begin
						detach_left--;
						fire_det = (detach_left == 0);
					end
					if (inter_left != 0) begin
						inter_left--;
						fire_int = (inter_left == 0);
					end
					if (return_left != 0) begin
						return_left--;
						fire_ret = (return_left == 0);
					end
					if (fire_det)
						drive_on = 1'b0;
					if (fire_int) begin
						angle_now = clip_angle(held_inter);
						s.position_written = 1'b1;
					end
					if (fire_ret) begin
						angle_now = clip_angle(rest_deg);
						detach_left = load_delay(DETACH_MS & 32'h1FF);
						s.position_written = 1'b1;
					end
				end
				CMD_DISPENSE, CMD_DISPENSE_INTER: begin
					if (!drive_on) begin
						drive_on = 1'b1;
						angle_now = clip_angle(rest_deg);
					end
					angle_now = clip_angle(feed);
					if (c == CMD_DISPENSE_INTER) begin
						held_inter = inter;
						inter_left = load_delay(secs * TICKS_PER_SEC);
						return_left = load_delay((secs + secs / 2) * TICKS_PER_SEC);
					end else begin
						return_left = load_delay(secs * TICKS_PER_SEC);
					end
					s.position_written = 1'b1;
				end
				default: begin
				end
			endcase
			s.servo_angle        = angle_now;
			s.attached           = drive_on;
			s.return_armed       = (return_left != 0);
			s.intermediate_armed = (inter_left != 0);
			s.detach_armed       = (detach_left != 0);
			expected_status.push_back(s);
		endfunction

		function void check_status(status_t got);
			status_t e;
			if (expected_status.size() == 0) begin
				$error("status beat arrived with no command outstanding");
				errors++;
				return;
			end
			e = expected_status.pop_front();
			if (got.servo_angle !== e.servo_angle) begin
				$error("servo_angle: expected %0d, actual %0d", e.servo_angle, got.servo_angle);
				errors++;
			end
			if (got.attached !== e.attached) begin
				$error("attached: expected %0b, actual %0b", e.attached, got.attached);
				errors++;
			end
			if (got.position_written !== e.position_written) begin
				$error("position_written: expected %0b, actual %0b",
					e.position_written, got.position_written);
				errors++;
			end
			if (got.return_armed !== e.return_armed) begin
				$error("return_armed: expected %0b, actual %0b",
					e.return_armed, got.return_armed);
				errors++;
			end
			if (got.intermediate_armed !== e.intermediate_armed) begin
				$error("intermediate_armed: expected %0b, actual %0b",
					e.intermediate_armed, got.intermediate_armed);
				errors++;
			end
			if (got.detach_armed !== e.detach_armed) begin
				$error("detach_armed: expected %0b, actual %0b",
					e.detach_armed, got.detach_armed);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	bit         idle_on;
	int unsigned ready_hold;

	servo_status_board sb;

	svf_cmd_if item_ch();
	svf_res_if res_ch();

	servo_feed_sequencer #(
		.DETACH_DELAY_MS(DETACH_MS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_angle();
		if ($urandom_range(0, 9) < 8)
			return 8'($urandom_range(0, 180));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] pick_dur();
		if ($urandom_range(0, 9) < 8)
			return 16'd0;
		return 16'($urandom_range(0, 65535));
	endfunction

	always @(posedge clk) begin
		status_t got;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				sb.note_command(cmd_t'(item_ch.command), item_ch.feed_angle,
					item_ch.intermediate_angle, item_ch.duration_sec);
			if (res_ch.valid && res_ch.ready) begin
				got.servo_angle        = res_ch.servo_angle;
				got.attached           = res_ch.attached;
				got.position_written   = res_ch.position_written;
				got.return_armed       = res_ch.return_armed;
				got.intermediate_armed = res_ch.intermediate_armed;
				got.detach_armed       = res_ch.detach_armed;
				sb.check_status(got);
			end
		end
	end

	always @(negedge clk) begin
		int unsigned n;
		if (!idle_on) begin
			res_ch.ready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold--;
			res_ch.ready <= 1'b0;
		end else begin
			n = gap_len();
			if (n == 0) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b0;
				ready_hold = n - 1;
			end
		end
	end

	task automatic send_beat(cmd_t c, logic [7:0] f, logic [7:0] ia, logic [15:0] d);
		int unsigned gap;
		gap = idle_on ? gap_len() : 0;
		@(negedge clk);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid              <= 1'b1;
		item_ch.command            <= c;
		item_ch.feed_angle         <= f;
		item_ch.intermediate_angle <= ia;
		item_ch.duration_sec       <= d;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
	endtask

	task automatic send_ticks(int unsigned n);
		repeat (n) send_beat(CMD_TICK, pick_angle(), pick_angle(), pick_dur());
	endtask

	task automatic write_rest(logic [7:0] v);
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.count() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		sb.set_rest(v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_rounds(int unsigned rounds);
		int unsigned r;
		repeat (rounds) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				send_beat($urandom_range(0, 1) ? CMD_DISPENSE : CMD_DISPENSE_INTER,
					pick_angle(), pick_angle(), pick_dur());
				send_ticks($urandom_range(0, 4));
			end else if (r < 70) begin
				send_ticks($urandom_range(1, 8));
			end else if (r < 85) begin
				send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			end else begin
				send_beat(CMD_DISPENSE, pick_angle(), pick_angle(), 16'd0);
				send_ticks(1);
				send_beat(CMD_DISPENSE_INTER, pick_angle(), pick_angle(), 16'd0);
				send_ticks($urandom_range(1, 3));
			end
		end
	endtask

	task automatic deep_sequence();
		// Detach, intermediate and return all fire on the same tick.
		send_beat(CMD_DISPENSE, 8'd120, 8'd0, 16'd0);
		send_ticks(1);
		send_ticks(DETACH_MS - 1);
		send_beat(CMD_DISPENSE_INTER, 8'd200, 8'd250, 16'd0);
		send_ticks(2);
	endtask

	initial begin
		sb = new();
		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_wdata                  = 8'd0;
		idle_on                    = 1'b0;
		ready_hold                 = 0;
		item_ch.valid              = 1'b0;
		item_ch.command            = CMD_TICK;
		item_ch.feed_angle         = 8'd0;
		item_ch.intermediate_angle = 8'd0;
		item_ch.duration_sec       = 16'd0;
		res_ch.ready               = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_beat(CMD_TICK, 8'd0, 8'd0, 16'd0);
		send_beat(CMD_NOP, 8'd255, 8'd255, 16'd65535);
		send_beat(CMD_DISPENSE, 8'd200, 8'd0, 16'd0);
		send_beat(CMD_TICK, 8'd0, 8'd0, 16'd0);
		send_beat(CMD_DISPENSE_INTER, 8'd0, 8'd255, 16'd0);
		send_beat(CMD_TICK, 8'd0, 8'd0, 16'd0);
		send_beat(CMD_DISPENSE, 8'd180, 8'd0, 16'd65535);
		send_beat(CMD_DISPENSE_INTER, 8'd45, 8'd135, 16'd65535);
		send_beat(CMD_DISPENSE, 8'd10, 8'd0, 16'd0);
		send_beat(CMD_TICK, 8'd255, 8'd255, 16'd65535);
		send_beat(CMD_NOP, 8'd0, 8'd0, 16'd0);
		send_beat(CMD_DISPENSE_INTER, 8'd181, 8'd181, 16'd1);
		send_beat(CMD_TICK, 8'd0, 8'd0, 16'd0);

		write_rest(8'd0);
		idle_on = 1'b1;
		random_rounds(5);

		write_rest(8'd255);
		random_rounds(5);

		write_rest(8'd180);
		deep_sequence();
		random_rounds(5);

		write_rest(8'($urandom_range(0, 180)));
		random_rounds(5);

		write_rest(8'($urandom_range(0, 255)));
		idle_on = 1'b0;
		random_rounds(3);
		idle_on = 1'b1;
		random_rounds(3);

		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.count() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("servo_feed_sequencer verification clean");
		else
			$display("servo_feed_sequencer verification failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("servo_feed_sequencer verification failed");
		$finish;
	end

endmodule

FILE: servo_feed_sequencer.f
hw/rtl/svf_pkg.sv
hw/rtl/svf_if.sv
hw/rtl/svf_in_stage.sv
hw/rtl/svf_core.sv
hw/rtl/servo_feed_sequencer.sv
sim/tb_top.sv
